// File: hdl/exit_air_temp_estimator_core_defines.svh
// Assertion macros shared by the exit air temperature estimator RTL.
// Each macro expects clock aclk and active-low reset aresetn in scope.
`ifndef EXIT_AIR_TEMP_ESTIMATOR_CORE_DEFINES_SVH
`define EXIT_AIR_TEMP_ESTIMATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define EATE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("estimator assertion failed");

// Next-cycle implication, checked outside reset.
`define EATE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("estimator assertion failed");

`endif

// File: hdl/eate_pkg.sv
// Shared types and constants of the exit air temperature estimator.
// No dependencies; used by every module of the block except eate_div.
`default_nettype none
package eate_pkg;

    typedef enum logic [1:0] {
        STATUS_OK            = 2'd0,
        STATUS_FLOW_ERR      = 2'd1,
        STATUS_INLET_MISSING = 2'd2,
        STATUS_POWER_ZERO    = 2'd3
    } status_t;

    localparam logic [2:0] CFG_PF_LOW     = 3'd0;
    localparam logic [2:0] CFG_PF_HIGH    = 3'd1;
    localparam logic [2:0] CFG_FLOW_LOW   = 3'd2;
    localparam logic [2:0] CFG_FLOW_HIGH  = 3'd3;
    localparam logic [2:0] CFG_ALPHA_SLOW = 3'd4;
    localparam logic [2:0] CFG_ALPHA_FAST = 3'd5;
    localparam logic [2:0] CFG_PWR_OFFSET = 3'd6;

    localparam int DIV_NUM_W = 50;
    localparam int DIV_DEN_W = 30;

    typedef struct packed {
        logic load_in;
        logic div_start;
        logic div_rise;
        logic interp_alpha;
        logic store_interp;
        logic calc_pc;
        logic calc_prod;
        logic store_raw;
        logic seed;
        logic calc_w;
        logic calc_upd;
        logic commit_upd;
        logic out_ok;
        logic out_special;
    } cmd_t;

    typedef struct packed {
        logic special;
        logic pc_zero;
        logic have_hist;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

// File: hdl/eate_div.sv
// Restoring unsigned divider, one quotient bit per clock.
// No dependencies.
`default_nettype none
module eate_div #(
    parameter int NUM_W = 50,
    parameter int DEN_W = 30
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic      [NUM_W-1:0] quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] trial;
    logic             ge;

    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den_reg};
    assign ge      = ~trial[DEN_W+1];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end else if (busy_reg) begin
            rem_next = ge ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule
`default_nettype wire

// File: hdl/eate_datapath.sv
// Datapath of the exit air temperature estimator: configuration, state,
// arithmetic and result register. Depends on eate_pkg and eate_div.
`default_nettype none
module eate_datapath #(
    parameter int ALPHA_FRAC_BITS = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [19:0]         cfg_data,
    input  wire logic [15:0]         in_airflow_total,
    input  wire logic [19:0]         in_power_total,
    input  wire logic signed [15:0]  in_inlet_temp,
    input  wire logic                in_inlet_valid,
    input  wire logic [15:0]         in_elapsed_seconds,
    input  wire logic                in_power_on,
    input  wire eate_pkg::cmd_t      cmd,
    output eate_pkg::sts_t           sts,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic signed [15:0]       out_exit_temp,
    output logic [1:0]               out_status
);
    localparam int AFB   = ALPHA_FRAC_BITS;
    localparam int UPD_W = 27 + AFB;
    localparam int NW    = eate_pkg::DIV_NUM_W;
    localparam int DW    = eate_pkg::DIV_DEN_W;
    localparam logic [31:0] ONE = 32'(1) << AFB;
    localparam logic signed [51:0]    RAW_MAX = 52'sd8388607;
    localparam logic signed [51:0]    RAW_MIN = -52'sd8388608;
    localparam logic signed [UPD_W:0] SUM_MAX = (UPD_W+1)'(8388607);
    localparam logic signed [UPD_W:0] SUM_MIN = -(UPD_W+1)'(8388608);

    logic [15:0] pf_low_reg, pf_high_reg, flow_low_reg, flow_high_reg;
    logic [15:0] alpha_slow_reg, alpha_fast_reg;
    logic signed [19:0] offset_reg;

    logic [15:0]        airflow_reg, secs_reg;
    logic [19:0]        power_reg;
    logic signed [15:0] inlet_reg;
    logic               inlet_ok_reg, pwr_reg;

    logic signed [23:0] avg_reg, avg_next;
    logic               hist_reg, hist_next;
    logic [15:0]        pending_reg, pending_next;

    logic [15:0]        interp_reg;
    logic               interp_neg_reg;
    logic signed [37:0] pc_reg;
    logic [29:0]        den_reg;
    logic [49:0]        prod_reg;
    logic               rise_neg_reg;
    logic signed [23:0] raw_reg;
    logic [AFB:0]       w_reg;
    logic signed [24:0] diff_reg;
    logic signed [UPD_W-1:0] upd_reg;

    logic               valid_reg;
    logic signed [15:0] temp_reg;
    logic [1:0]         status_reg;

    // Interpolation over airflow
    logic [15:0]        ip_lo, ip_hi, ip_off, ip_den, ip_res;
    logic               ip_lo_end, ip_hi_end, ip_neg;
    logic signed [16:0] ip_span;
    logic signed [33:0] ip_prod;
    logic [31:0]        ip_mag;
    logic signed [17:0] ip_sq, ip_sum;

    logic [NW-1:0] div_num, div_quo;
    logic [DW-1:0] div_den;
    logic          div_done;

    logic [35:0]        pmul;
    logic signed [37:0] pc_next;
    logic [37:0]        pc_mag;
    logic signed [51:0] raw_wide;
    logic signed [23:0] raw_sat;
    logic [16:0]        pend_sum;
    logic [15:0]        dt, pend_sat;
    logic [31:0]        wp;
    logic [UPD_W-1:0]   upd_mag, upd_r;
    logic signed [UPD_W-1:0] upd_s;
    logic signed [UPD_W:0]   avg_sum;
    logic signed [15:0] avg_sat16, spc_temp;
    eate_pkg::status_t  spc_code;

    always_comb begin
        ip_lo     = cmd.interp_alpha ? alpha_slow_reg : pf_low_reg;
        ip_hi     = cmd.interp_alpha ? alpha_fast_reg : pf_high_reg;
        ip_lo_end = (flow_high_reg <= flow_low_reg) || (airflow_reg <= flow_low_reg);
        ip_hi_end = airflow_reg >= flow_high_reg;
        ip_span   = $signed({1'b0, ip_hi}) - $signed({1'b0, ip_lo});
        ip_off    = airflow_reg - flow_low_reg;
        ip_den    = flow_high_reg - flow_low_reg;
        ip_prod   = ip_span * $signed({1'b0, ip_off});
        ip_neg    = ip_prod[33];
        ip_mag    = ip_neg ? 32'(-ip_prod) : ip_prod[31:0];
        ip_sq     = interp_neg_reg ? -$signed({1'b0, div_quo[16:0]})
                                   : $signed({1'b0, div_quo[16:0]});
        ip_sum    = $signed({2'b00, ip_lo}) + ip_sq;
        ip_res    = ip_lo_end ? ip_lo : (ip_hi_end ? ip_hi : ip_sum[15:0]);
    end

    always_comb begin
        if (cmd.div_rise) begin
            div_num = prod_reg + {21'd0, den_reg[29:1]};
            div_den = den_reg;
        end else begin
            div_num = {18'd0, ip_mag};
            div_den = {14'd0, ip_den};
        end
    end

    eate_div #(
        .NUM_W (NW),
        .DEN_W (DW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_comb begin
        pmul     = power_reg * interp_reg;
        pc_next  = $signed({2'b00, pmul}) + $signed({{6{offset_reg[19]}}, offset_reg, 12'd0});
        pc_mag   = pc_reg[37] ? 38'(-pc_reg) : pc_reg;
        raw_wide = $signed({{36{inlet_reg[15]}}, inlet_reg})
                 + (rise_neg_reg ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo}));
        if (raw_wide > RAW_MAX) begin
            raw_sat = 24'sh7FFFFF;
        end else if (raw_wide < RAW_MIN) begin
            raw_sat = -24'sh800000;
        end else begin
            raw_sat = raw_wide[23:0];
        end
        pend_sum = {1'b0, pending_reg} + {1'b0, secs_reg};
        pend_sat = pend_sum[16] ? 16'hFFFF : pend_sum[15:0];
        dt       = pend_sat;
        wp       = dt * interp_reg;
        upd_mag  = upd_reg[UPD_W-1] ? UPD_W'(-upd_reg) : UPD_W'(upd_reg);
        upd_r    = (upd_mag + (UPD_W'(1) << (AFB - 1))) >> AFB;
        upd_s    = upd_reg[UPD_W-1] ? -$signed(upd_r) : $signed(upd_r);
        avg_sum  = $signed({{(UPD_W-23){avg_reg[23]}}, avg_reg}) + $signed({upd_s[UPD_W-1], upd_s});
        if (avg_reg > 24'sd32767) begin
            avg_sat16 = 16'sh7FFF;
        end else if (avg_reg < -24'sd32768) begin
            avg_sat16 = -16'sh8000;
        end else begin
            avg_sat16 = avg_reg[15:0];
        end
        spc_temp = '0;
        if (airflow_reg == 16'd0) begin
            spc_code = eate_pkg::STATUS_FLOW_ERR;
        end else if (!inlet_ok_reg) begin
            spc_code = eate_pkg::STATUS_INLET_MISSING;
        end else if (!pwr_reg) begin
            spc_code = eate_pkg::STATUS_OK;
            spc_temp = inlet_reg;
        end else begin
            spc_code = eate_pkg::STATUS_POWER_ZERO;
        end
    end

    always_comb begin
        avg_next     = avg_reg;
        hist_next    = hist_reg;
        pending_next = pending_reg;
        if (cmd.seed) begin
            avg_next     = raw_reg;
            hist_next    = 1'b1;
            pending_next = '0;
        end else if (cmd.commit_upd) begin
            if (avg_sum > SUM_MAX) begin
                avg_next = 24'sh7FFFFF;
            end else if (avg_sum < SUM_MIN) begin
                avg_next = -24'sh800000;
            end else begin
                avg_next = avg_sum[23:0];
            end
            pending_next = '0;
        end else if (cmd.out_special) begin
            pending_next = pend_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pf_low_reg     <= 16'd4096;
            pf_high_reg    <= 16'd4096;
            flow_low_reg   <= 16'd160;
            flow_high_reg  <= 16'd16000;
            alpha_slow_reg <= 16'd655;
            alpha_fast_reg <= 16'd6554;
            offset_reg     <= '0;
            avg_reg        <= '0;
            hist_reg       <= 1'b0;
            pending_reg    <= '0;
            valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    eate_pkg::CFG_PF_LOW:     pf_low_reg     <= cfg_data[15:0];
                    eate_pkg::CFG_PF_HIGH:    pf_high_reg    <= cfg_data[15:0];
                    eate_pkg::CFG_FLOW_LOW:   flow_low_reg   <= cfg_data[15:0];
                    eate_pkg::CFG_FLOW_HIGH:  flow_high_reg  <= cfg_data[15:0];
                    eate_pkg::CFG_ALPHA_SLOW: alpha_slow_reg <= cfg_data[15:0];
                    eate_pkg::CFG_ALPHA_FAST: alpha_fast_reg <= cfg_data[15:0];
                    eate_pkg::CFG_PWR_OFFSET: offset_reg     <= cfg_data;
                    default: ;
                endcase
            end
            avg_reg     <= avg_next;
            hist_reg    <= hist_next;
            pending_reg <= pending_next;
            if (cmd.out_ok || cmd.out_special) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
        if (cmd.load_in) begin
            airflow_reg  <= in_airflow_total;
            power_reg    <= in_power_total;
            inlet_reg    <= in_inlet_temp;
            inlet_ok_reg <= in_inlet_valid;
            secs_reg     <= in_elapsed_seconds;
            pwr_reg      <= in_power_on;
        end
        if (cmd.div_start && !cmd.div_rise) begin
            interp_neg_reg <= ip_neg;
        end
        if (cmd.store_interp) begin
            interp_reg <= ip_res;
        end
        if (cmd.calc_pc) begin
            pc_reg  <= pc_next;
            den_reg <= 30'(airflow_reg) * 30'd10000;
        end
        if (cmd.calc_prod) begin
            prod_reg     <= 50'(pc_mag) * 50'd1254;
            rise_neg_reg <= pc_reg[37];
        end
        if (cmd.store_raw) begin
            raw_reg <= raw_sat;
        end
        if (cmd.calc_w) begin
            w_reg    <= (wp > ONE) ? ONE[AFB:0] : wp[AFB:0];
            diff_reg <= $signed({raw_reg[23], raw_reg}) - $signed({avg_reg[23], avg_reg});
        end
        if (cmd.calc_upd) begin
            upd_reg <= diff_reg * $signed({1'b0, w_reg});
        end
        if (cmd.out_ok) begin
            temp_reg   <= avg_sat16;
            status_reg <= eate_pkg::STATUS_OK;
        end else if (cmd.out_special) begin
            temp_reg   <= spc_temp;
            status_reg <= spc_code;
        end
    end

    assign sts.special   = (airflow_reg == 16'd0) || !inlet_ok_reg || !pwr_reg;
    assign sts.pc_zero   = (pc_reg == 38'sd0);
    assign sts.have_hist = hist_reg;
    assign sts.div_done  = div_done;
    assign sts.out_free  = !valid_reg || m_tready;

    assign m_tvalid      = valid_reg;
    assign out_exit_temp = temp_reg;
    assign out_status    = status_reg;
endmodule
`default_nettype wire

// File: hdl/eate_ctrl.sv
// Controller of the exit air temperature estimator: sequences the datapath.
// Depends on eate_pkg and the assertion macro header.
`default_nettype none
`include "exit_air_temp_estimator_core_defines.svh"
module eate_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire eate_pkg::sts_t sts,
    output eate_pkg::cmd_t      cmd
);
    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_CLASS  = 13'b0000000000010,
        S_DIVF   = 13'b0000000000100,
        S_PCMUL  = 13'b0000000001000,
        S_PCCHK  = 13'b0000000010000,
        S_RSTART = 13'b0000000100000,
        S_RDIV   = 13'b0000001000000,
        S_RAW    = 13'b0000010000000,
        S_ADIV   = 13'b0000100000000,
        S_WMUL   = 13'b0001000000000,
        S_UMUL   = 13'b0010000000000,
        S_UPD    = 13'b0100000000000,
        S_OUT    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   special_reg, special_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        special_next = special_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CLASS;
                end
            end
            S_CLASS: begin
                if (sts.special) begin
                    special_next = 1'b1;
                    state_next   = S_OUT;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIVF;
                end
            end
            S_DIVF: begin
                if (sts.div_done) begin
                    cmd.store_interp = 1'b1;
                    state_next       = S_PCMUL;
                end
            end
            S_PCMUL: begin
                cmd.calc_pc = 1'b1;
                state_next  = S_PCCHK;
            end
            S_PCCHK: begin
                if (sts.pc_zero) begin
                    special_next = 1'b1;
                    state_next   = S_OUT;
                end else begin
                    cmd.calc_prod = 1'b1;
                    state_next    = S_RSTART;
                end
            end
            S_RSTART: begin
                cmd.div_start = 1'b1;
                cmd.div_rise  = 1'b1;
                state_next    = S_RDIV;
            end
            S_RDIV: begin
                if (sts.div_done) begin
                    cmd.store_raw = 1'b1;
                    state_next    = S_RAW;
                end
            end
            S_RAW: begin
                special_next = 1'b0;
                if (!sts.have_hist) begin
                    cmd.seed   = 1'b1;
                    state_next = S_OUT;
                end else begin
                    cmd.div_start    = 1'b1;
                    cmd.interp_alpha = 1'b1;
                    state_next       = S_ADIV;
                end
            end
            S_ADIV: begin
                cmd.interp_alpha = 1'b1;
                if (sts.div_done) begin
                    cmd.store_interp = 1'b1;
                    state_next       = S_WMUL;
                end
            end
            S_WMUL: begin
                cmd.calc_w = 1'b1;
                state_next = S_UMUL;
            end
            S_UMUL: begin
                cmd.calc_upd = 1'b1;
                state_next   = S_UPD;
            end
            S_UPD: begin
                cmd.commit_upd = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.out_special = special_reg;
                    cmd.out_ok      = !special_reg;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            special_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            special_reg <= special_next;
        end
    end

    `EATE_ASSERT_IMPL(a_load_free, (cmd.out_ok || cmd.out_special), sts.out_free)
    `EATE_ASSERT_IMPL(a_done_wait, sts.div_done, (state_reg == S_DIVF || state_reg == S_RDIV || state_reg == S_ADIV))
    `EATE_ASSERT_NEXT(a_accept_class, (s_tvalid && s_tready), (state_reg == S_CLASS))
endmodule
`default_nettype wire

// File: hdl/exit_air_temp_estimator_core.sv
// Exit air temperature estimator, top level.
// Depends on eate_pkg, eate_ctrl, eate_datapath and eate_div.
//
// One result follows every input transfer. An item with zero airflow, a
// missing inlet reading or host power off skips the divider and goes straight
// to its result. Every other item runs the shared one-bit-per-cycle divider:
// an item whose corrected power is zero runs it once, the first successful
// item runs it twice, and later successful items run it three times. A new
// item is taken while a finished result still waits on the master side. The
// user must write configuration only when no item is in progress; the block
// itself does not enforce it.
`default_nettype none
module exit_air_temp_estimator_core #(
    parameter int ALPHA_FRAC_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [19:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // airflow_total[15:0], power_total[35:16], inlet_temp[51:36],
    // elapsed_seconds[67:52], power_on[68], zero padding
    input  wire logic [71:0] s_tdata,
    // inlet_valid[0]
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // exit_temp[15:0]
    output logic [15:0]      m_tdata,
    // status[1:0]
    output logic [1:0]       m_tuser
);
    eate_pkg::cmd_t cmd;
    eate_pkg::sts_t sts;
    logic signed [15:0] exit_temp;

    assign cfg_ready = 1'b1;

    eate_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    eate_datapath #(
        .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_valid && cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_airflow_total   (s_tdata[15:0]),
        .in_power_total     (s_tdata[35:16]),
        .in_inlet_temp      ($signed(s_tdata[51:36])),
        .in_inlet_valid     (s_tuser),
        .in_elapsed_seconds (s_tdata[67:52]),
        .in_power_on        (s_tdata[68]),
        .cmd                (cmd),
        .sts                (sts),
        .m_tvalid           (m_tvalid),
        .m_tready           (m_tready),
        .out_exit_temp      (exit_temp),
        .out_status         (m_tuser)
    );

    assign m_tdata = exit_temp;
endmodule
`default_nettype wire

// File: test/eate_checker.sv
// Checker for the exit air temperature estimator: watches the configuration,
// input and result channels, predicts each result and compares it.
// Depends on eate_pkg.
`timescale 1ns / 100ps
`default_nettype none
module eate_checker #(
    parameter int ALPHA_FRAC_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [19:0] cfg_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [71:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,
    input  wire logic [1:0]  m_tuser,
    output int               fail_count,
    output int               pending_count
);
    typedef struct packed {
        logic [15:0]       temp;
        eate_pkg::status_t status;
    } estimate_t;

    estimate_t expected_estimates[$];

    longint pf_low, pf_high, knee_low, knee_high, a_slow, a_fast, offset_w;
    longint avg_temp, secs_pending;
    bit     seeded;

    function automatic longint round_div(longint num, longint den);
        longint mag;
        mag = (num < 0) ? -num : num;
        mag = (mag + den / 2) / den;
        return (num < 0) ? -mag : mag;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint blend(longint lo, longint hi, longint flow);
        if (knee_high <= knee_low || flow <= knee_low) return lo;
        if (flow >= knee_high) return hi;
        return lo + ((hi - lo) * (flow - knee_low)) / (knee_high - knee_low);
    endfunction

    function automatic estimate_t estimate(logic [71:0] d, logic inlet_ok);
        longint flow, pwr, inlet, secs, fac, pc, rise, raw, alpha, dt, w, one;
        estimate_t r;
        flow  = d[15:0];
        pwr   = d[35:16];
        inlet = longint'($signed(d[51:36]));
        secs  = d[67:52];
        one   = longint'(1) << ALPHA_FRAC_BITS;
        r.temp = '0;
        r.status = eate_pkg::STATUS_OK;
        if (flow == 0) r.status = eate_pkg::STATUS_FLOW_ERR;
        else if (!inlet_ok) r.status = eate_pkg::STATUS_INLET_MISSING;
        else if (!d[68]) r.temp = d[51:36];
        else begin
            fac = blend(pf_low, pf_high, flow);
            pc = pwr * fac + offset_w * 4096;
            if (pc == 0) r.status = eate_pkg::STATUS_POWER_ZERO;
            else begin
                rise = round_div(pc * 1254, flow * 10000);
                raw = clamp(inlet + rise, -8388608, 8388607);
                if (!seeded) begin
                    seeded = 1;
                    avg_temp = raw;
                end else begin
                    dt = clamp(secs_pending + secs, 0, 65535);
                    alpha = blend(a_slow, a_fast, flow);
                    w = clamp(dt * alpha, 0, one);
                    avg_temp = clamp(avg_temp + round_div((raw - avg_temp) * w, one),
                                     -8388608, 8388607);
                end
                secs_pending = 0;
                r.temp = 16'(clamp(avg_temp, -32768, 32767));
                return r;
            end
        end
        secs_pending = clamp(secs_pending + secs, 0, 65535);
        return r;
    endfunction

    assign pending_count = expected_estimates.size();

    always @(posedge aclk) begin
        estimate_t want;
        if (!aresetn) begin
            pf_low = 4096; pf_high = 4096; knee_low = 160; knee_high = 16000;
            a_slow = 655; a_fast = 6554; offset_w = 0;
            avg_temp = 0; seeded = 0; secs_pending = 0;
            fail_count <= 0;
            expected_estimates.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    eate_pkg::CFG_PF_LOW:     pf_low    = cfg_data[15:0];
                    eate_pkg::CFG_PF_HIGH:    pf_high   = cfg_data[15:0];
                    eate_pkg::CFG_FLOW_LOW:   knee_low  = cfg_data[15:0];
                    eate_pkg::CFG_FLOW_HIGH:  knee_high = cfg_data[15:0];
                    eate_pkg::CFG_ALPHA_SLOW: a_slow    = cfg_data[15:0];
                    eate_pkg::CFG_ALPHA_FAST: a_fast    = cfg_data[15:0];
                    eate_pkg::CFG_PWR_OFFSET: offset_w  = longint'($signed(cfg_data));
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_estimates.push_back(estimate(s_tdata, s_tuser));
            if (m_tvalid && m_tready) begin
                if (expected_estimates.size() == 0) begin
                    $display("%0t: unexpected result temp=%h status=%0d", $time,
                             m_tdata, m_tuser);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_estimates.pop_front();
                    if (want.temp !== m_tdata || want.status !== m_tuser) begin
                        $display("%0t: expected temp=%h status=%0d, got temp=%h status=%0d",
                                 $time, want.temp, want.status, m_tdata, m_tuser);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// File: test/testbench.sv
// Top of the estimator testbench: clock, reset, configuration and item
// stimulus with random idling, and the verdict. Depends on eate_pkg,
// eate_checker and exit_air_temp_estimator_core.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    localparam int STALL_LIMIT = 20000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_valid = 0;
    logic [2:0]  cfg_index = '0;
    logic [19:0] cfg_data = '0;
    logic        s_tvalid = 0;
    logic [71:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        m_tready = 0;
    wire         cfg_ready, s_tready, m_tvalid;
    wire  [15:0] m_tdata;
    wire  [1:0]  m_tuser;
    int          fail_count, pending_count;
    int          send_idle = 0, recv_stall = 0, quiet_cycles = 0;

    always #2 aclk = ~aclk;

    exit_air_temp_estimator_core uut (.*);
    eate_checker checker_i (.*);

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall);
        if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [19:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic drain_results;
        s_tvalid <= 0;
        while (pending_count != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic send_reading(logic [15:0] flow, logic [19:0] pwr, logic [15:0] inlet,
                                logic inlet_ok, logic [15:0] secs, logic pwr_on);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tdata  <= {3'b0, pwr_on, secs, inlet, pwr, flow};
        s_tuser  <= inlet_ok;
        s_tvalid <= 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic random_reading;
        logic [15:0] flow, secs;
        logic [19:0] pwr;
        int k;
        k = $urandom_range(99);
        flow = (k < 5) ? 16'd0 : (k < 50) ? 16'($urandom_range(100, 20000))
                                          : 16'($urandom);
        pwr  = (k % 7 == 0) ? 20'($urandom_range(3)) : 20'($urandom);
        secs = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(30));
        send_reading(flow, pwr, 16'($urandom), $urandom_range(19) != 0, secs,
                     $urandom_range(9) != 0);
    endtask

    task automatic random_config(bit extreme);
        int i;
        for (i = 0; i < 6; i++)
            write_reg(3'(i), extreme ? ($urandom_range(1) ? 20'hFFFF : 20'h0)
                                     : 20'($urandom_range(65535)));
        write_reg(eate_pkg::CFG_PWR_OFFSET,
                  extreme ? ($urandom_range(1) ? 20'h80000 : 20'h7FFFF) : 20'($urandom));
    endtask

    initial begin
        int phase, n;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // Directed: each status, pass-through, seeding, knees, extremes.
        send_reading(16'd0, 20'd1000, 16'h1900, 1, 16'd5, 1);
        send_reading(16'd800, 20'd1000, 16'h1900, 0, 16'd5, 1);
        send_reading(16'd800, 20'd1000, 16'h8000, 1, 16'd5, 0);
        send_reading(16'd800, 20'd0, 16'h1900, 1, 16'd5, 1);
        send_reading(16'd800, 20'd16000, 16'h1900, 1, 16'd3, 1);
        send_reading(16'd100, 20'hFFFFF, 16'h7FFF, 1, 16'hFFFF, 1);
        send_reading(16'hFFFF, 20'hFFFFF, 16'h8000, 1, 16'd1, 1);
        send_reading(16'd1, 20'hFFFFF, 16'h7FFF, 1, 16'd0, 1);
        send_reading(16'd16000, 20'd500, 16'h0000, 1, 16'hFFFF, 1);
        send_reading(16'd5000, 20'd500, 16'hFFFF, 1, 16'hFFFF, 0);
        send_reading(16'd5000, 20'd500, 16'hFFFF, 1, 16'hFFFF, 1);
        drain_results();
        write_reg(eate_pkg::CFG_FLOW_LOW, 20'd9000);
        write_reg(eate_pkg::CFG_FLOW_HIGH, 20'd9000);
        write_reg(eate_pkg::CFG_PWR_OFFSET, 20'hFFF00);
        send_reading(16'd20000, 20'd16, 16'h1000, 1, 16'd2, 1);
        send_reading(16'd20000, 20'd4, 16'h1000, 1, 16'd2, 1);
        send_reading(16'd20000, 20'd3000, 16'h1000, 1, 16'd2, 1);
        drain_results();
        for (phase = 0; phase < 8; phase++) begin
            send_idle  = (phase % 4 == 1) ? 55 : (phase % 4 == 3) ? 23 : 0;
            recv_stall = (phase % 4 == 2) ? 55 : (phase % 4 == 3) ? 23 : 0;
            random_config(phase == 2 || phase == 5);
            for (n = 0; n < 245; n++) random_reading();
            drain_results();
        end
        if (fail_count == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
